>>> sv/rlcu_pkg.sv
// Package: widths, operation and status codes for the row list cursor undo engine
`default_nettype none
package rlcu_pkg;
  localparam int MaxRows = 1024;
  localparam int RowW = $clog2(MaxRows);
  localparam int LinkW = RowW + 1;
  localparam int CntW = RowW + 1;
  localparam int StackW = RowW + 2 * LinkW;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_DOWN    = 3'd1,
    OP_UP      = 3'd2,
    OP_DELETE  = 3'd3,
    OP_RESTORE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_SOLE    = 2'd2,
    ST_END     = 2'd3
  } status_t;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_START_CURSOR = 1'b1;
endpackage
`default_nettype wire

>>> sv/row_list_cursor_undo_engine.sv
// Top level: row list with cursor and undo stack, sequenced over link memories
//
// Each word on in_ is worked through a sequence of states; in_tready is low while
// one is being worked. A start word walks all 1024 rows once, linking and marking
// the rows in use and clearing the presence of the rest. A move follows one link
// per step, reading it in S_MV_RD and checking it in S_MV_CHK. The link, presence
// and stack memories are single-port. After reset a clearing pass over all 1024
// rows zeroes the presence memory before the first word is taken.
// Result word layout in out_tdata: cursor_row [9:0], row_present [10],
// status [12:11].
`default_nettype none
module row_list_cursor_undo_engine
  import rlcu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // operation, distance, query_row
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // cursor_row, row_present, status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_START, S_MV_RD, S_MV_CHK, S_DEL_RD, S_DEL_WR,
    S_RS_RD, S_RS_WR, S_RS_PV, S_QRD, S_QWAIT, S_OUT
  } state_t;

  state_t state_r;
  logic [CntW-1:0] row_count_r, n_r, live_r, depth_r, idx_r;
  logic [RowW-1:0] start_cur_r, cursor_r, query_r, dist_r;
  logic [2:0] op_r;
  logic [1:0] status_r;
  logic [LinkW-1:0] nx_r, pv_r;
  logic [StackW-1:0] ent_r;
  logic pres_r, ph_r;

  logic nl_we, pl_we, pm_we, st_we;
  logic [RowW-1:0] nl_a, pl_a, pm_a, st_a;
  logic [LinkW-1:0] nl_wd, pl_wd, nl_rd, pl_rd;
  logic pm_wd, pm_rd;
  logic [StackW-1:0] st_rd;

  rlcu_ram #(.Width(LinkW), .Depth(MaxRows)) u_next (.clk, .we(nl_we), .addr(nl_a),
    .wdata(nl_wd), .rdata(nl_rd));
  rlcu_ram #(.Width(LinkW), .Depth(MaxRows)) u_prev (.clk, .we(pl_we), .addr(pl_a),
    .wdata(pl_wd), .rdata(pl_rd));
  rlcu_ram #(.Width(1), .Depth(MaxRows)) u_pres (.clk, .we(pm_we), .addr(pm_a),
    .wdata(pm_wd), .rdata(pm_rd));
  rlcu_ram #(.Width(StackW), .Depth(MaxRows)) u_stack (.clk, .we(st_we),
    .addr(st_a), .wdata({pv_r, nx_r, cursor_r}), .rdata(st_rd));

  logic [RowW-1:0] e_row;
  logic [LinkW-1:0] e_nx, e_pv;
  assign e_row = ent_r[RowW-1:0];
  assign e_nx = ent_r[RowW+LinkW-1:RowW];
  assign e_pv = ent_r[StackW-1:RowW+LinkW];

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {3'd0, status_r, pres_r, cursor_r};

  always_comb begin
    nl_we = 1'b0; pl_we = 1'b0; pm_we = 1'b0; st_we = 1'b0;
    nl_a = cursor_r; pl_a = cursor_r; pm_a = query_r; st_a = depth_r[RowW-1:0];
    nl_wd = '0; pl_wd = '0; pm_wd = 1'b0;
    unique case (state_r)
      S_CLR: begin
        pm_we = 1'b1; pm_a = idx_r[RowW-1:0];
      end
      S_START: begin
        nl_we = (idx_r < n_r); pl_we = (idx_r < n_r); pm_we = 1'b1;
        nl_a = idx_r[RowW-1:0]; pl_a = idx_r[RowW-1:0]; pm_a = idx_r[RowW-1:0];
        nl_wd = (idx_r + 1'b1 < n_r) ? idx_r + 1'b1 : LinkW'(MaxRows);
        pl_wd = (idx_r == '0) ? LinkW'(MaxRows) : idx_r - 1'b1;
        pm_wd = (idx_r < n_r);
      end
      S_DEL_WR: begin
        unique case (ph_r)
          1'b0: begin
            pm_we = 1'b1; pm_a = cursor_r; st_we = 1'b1;
            nl_we = !pv_r[RowW]; nl_a = pv_r[RowW-1:0]; nl_wd = nx_r;
          end
          default: begin
            pl_we = !nx_r[RowW]; pl_a = nx_r[RowW-1:0]; pl_wd = pv_r;
          end
        endcase
      end
      S_RS_RD: st_a = depth_r[RowW-1:0] - 1'b1;
      S_RS_WR: begin
        nl_we = 1'b1; pl_we = 1'b1; pm_we = 1'b1;
        nl_a = e_row; pl_a = e_row; pm_a = e_row;
        nl_wd = e_nx; pl_wd = e_pv; pm_wd = 1'b1;
      end
      S_RS_PV: begin
        pl_we = !e_nx[RowW]; pl_a = e_nx[RowW-1:0]; pl_wd = {1'b0, e_row};
        nl_we = !e_pv[RowW]; nl_a = e_pv[RowW-1:0]; nl_wd = {1'b0, e_row};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r <= '0;
      row_count_r <= CntW'(8);
      start_cur_r <= '0;
      live_r <= '0;
      depth_r <= '0;
      cursor_r <= '0;
      ph_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_ROW_COUNT) row_count_r <= cfg_data;
        else start_cur_r <= cfg_data[RowW-1:0];
      end
      unique case (state_r)
        S_CLR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == CntW'(MaxRows - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          op_r <= in_tdata[2:0];
          dist_r <= in_tdata[12:3];
          query_r <= in_tdata[22:13];
          status_r <= ST_OK;
          idx_r <= '0;
          ph_r <= 1'b0;
          n_r <= (row_count_r == '0) ? CntW'(1) :
                 (row_count_r > CntW'(MaxRows)) ? CntW'(MaxRows) : row_count_r;
          unique case (in_tdata[2:0])
            OP_START: state_r <= S_START;
            OP_DOWN, OP_UP: begin
              if (in_tdata[12:3] == '0) state_r <= S_QRD;
              else if (live_r == '0) begin
                status_r <= ST_END; state_r <= S_QRD;
              end else state_r <= S_MV_RD;
            end
            OP_DELETE: begin
              if (live_r <= CntW'(1) || depth_r >= CntW'(MaxRows)) begin
                status_r <= ST_SOLE; state_r <= S_QRD;
              end else state_r <= S_DEL_RD;
            end
            OP_RESTORE: begin
              if (depth_r == '0) begin
                status_r <= ST_EMPTY; state_r <= S_QRD;
              end else state_r <= S_RS_RD;
            end
            default: state_r <= S_QRD;
          endcase
        end
        S_START: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == CntW'(MaxRows - 1)) begin
            depth_r <= '0;
            live_r <= n_r;
            cursor_r <= ({1'b0, start_cur_r} < n_r) ? start_cur_r :
                        RowW'(n_r - 1'b1);
            state_r <= S_QRD;
          end
        end
        S_MV_RD: state_r <= S_MV_CHK;
        S_MV_CHK: begin
          if ((op_r == OP_DOWN) ? nl_rd[RowW] : pl_rd[RowW]) begin
            status_r <= ST_END; state_r <= S_QRD;
          end else begin
            cursor_r <= (op_r == OP_DOWN) ? nl_rd[RowW-1:0] : pl_rd[RowW-1:0];
            dist_r <= dist_r - 1'b1;
            state_r <= (dist_r == RowW'(1)) ? S_QRD : S_MV_RD;
          end
        end
        S_DEL_RD: begin
          if (ph_r) begin
            nx_r <= nl_rd; pv_r <= pl_rd; ph_r <= 1'b0; state_r <= S_DEL_WR;
          end else ph_r <= 1'b1;
        end
        S_DEL_WR: begin
          if (ph_r) begin
            depth_r <= depth_r + 1'b1;
            live_r <= live_r - 1'b1;
            cursor_r <= nx_r[RowW] ? pv_r[RowW-1:0] : nx_r[RowW-1:0];
            state_r <= S_QRD;
          end else ph_r <= 1'b1;
        end
        S_RS_RD: begin
          if (ph_r) begin
            ent_r <= st_rd; ph_r <= 1'b0; depth_r <= depth_r - 1'b1;
            live_r <= live_r + 1'b1; state_r <= S_RS_WR;
          end else ph_r <= 1'b1;
        end
        S_RS_WR: state_r <= S_RS_PV;
        S_RS_PV: state_r <= S_QRD;
        S_QRD: state_r <= S_QWAIT;
        S_QWAIT: begin
          pres_r <= pm_rd; state_r <= S_OUT;
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/rlcu_ram.sv
// Generic single-port RAM with registered read
`default_nettype none
module rlcu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire
